// ----- rtl/lzd_pkg.sv -----
`default_nettype none
package lzd_pkg;

   localparam int WINDOW_DEPTH = 4096;
   localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [1:0] ACT_FEED  = 2'd0;
   localparam logic [1:0] ACT_DRAIN = 2'd1;
   localparam logic [1:0] ACT_START = 2'd2;
   localparam logic [1:0] ACT_NONE  = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BUSY     = 3'd1;
   localparam logic [2:0] ST_BAD_HDR  = 3'd2;
   localparam logic [2:0] ST_BAD_REF  = 3'd3;
   localparam logic [2:0] ST_TRUNC    = 3'd4;

   localparam logic [2:0] HDR_DONE    = 3'd4;
   localparam logic [3:0] FLAG_EMPTY  = 4'd8;

   typedef struct packed {
      logic       feed;
      logic       drain;
      logic       start;
      logic [7:0] data;
      logic       last;
   } lzd_item_type;

endpackage
`default_nettype wire

// ----- rtl/lz_stream_decompressor_top.sv -----
// channel | dir | tdata                               | tuser        | tlast
// req     | in  | [7:0] in_byte                       | [1:0] action | in_last
// rsp     | out | [7:0] out_byte, [8] copy_pending,   | out_valid    | stream_done
//         |     | [11:9] status, [15:12] zero         |              |
// csr     | in  | csr_wr_en, csr_wr_data[23:0] output_limit
// One request per cycle sustained while responses are taken; each request reaches its
// response through the queue entry, then decode into the response register.
// A copy byte reads the 4096-entry history through one registered read port; a
// distance-one copy is forwarded from the pending write.
// Reset is synchronous; history holds no reset value and needs no clearing.
// A stalled response holds the decoder; the two-entry queue accepts until full.
`default_nettype none
module lz_stream_decompressor_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,  // in_byte
   input  wire  [1:0]  req_tuser,  // action
   input  wire         req_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,  // out_byte, copy_pending, status, zero fill
   output logic        rsp_tuser,  // out_valid
   output logic        rsp_tlast,
   input  wire         csr_wr_en,
   input  wire  [23:0] csr_wr_data
);
   import lzd_pkg::*;

   logic         q_valid, q_pop;
   lzd_item_type q_item;

   lzd_front u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
   );

   lzd_back u_back (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

endmodule
`default_nettype wire

// ----- rtl/lzd_front.sv -----
`default_nettype none
module lzd_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  wire  [7:0]           req_tdata,
   input  wire  [1:0]           req_tuser,
   input  wire                  req_tlast,
   output logic                 q_valid,
   output lzd_pkg::lzd_item_type q_item,
   input  wire                  q_pop
);
   import lzd_pkg::*;

   lzd_item_type     mem_ff [QUEUE_DEPTH];
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;
   lzd_item_type     cls;
   logic             push;

   always_comb begin
      cls.feed  = (req_tuser == ACT_FEED);
      cls.drain = (req_tuser == ACT_DRAIN);
      cls.start = (req_tuser == ACT_START);
      cls.data  = req_tdata;
      cls.last  = req_tlast;
   end

   assign req_tready = (cnt_ff != 2'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (cnt_ff != 2'd0);
   assign q_item     = mem_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = q_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= cls;
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(QUEUE_DEPTH)) else $error("queue count overflow");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_cnt_track: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> cnt_ff == $past(cnt_ff) + 2'd1) else $error("count lost push");

endmodule
`default_nettype wire

// ----- rtl/lzd_back.sv -----
`default_nettype none
module lzd_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   csr_wr_en,
   input  wire  [23:0]           csr_wr_data,
   input  wire                   q_valid,
   input  lzd_pkg::lzd_item_type q_item,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output logic [15:0]           rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);
   import lzd_pkg::*;

   logic [7:0]  hist [WINDOW_DEPTH];

   logic [23:0] limit_ff;
   logic [23:0] dc_ff, dc_in, ts_ff, ts_in, tc_ff, tc_in;
   logic [2:0]  hi_ff, hi_in, st_ff, st_in;
   logic        v2_ff, v2_in, end_ff, end_in;
   logic [7:0]  fb_ff, fb_in;
   logic [3:0]  fp_ff, fp_in;
   logic [1:0]  tbc_ff, tbc_in;
   logic [16:0] cr_ff, cr_in;
   logic [11:0] co_ff, co_in;

   logic        b_vld_ff, b_ov_ff, b_cp_ff, b_done_ff, b_pend_ff;
   logic [2:0]  b_stat_ff;
   logic [7:0]  b_lit_ff, rd_ff, fwd_data_ff;
   logic        fwd_ff, wr_pend_ff;
   logic [WIN_AW-1:0] wr_addr_ff;

   logic        ov, is_cp, done_now;
   logic [2:0]  stat;
   logic [7:0]  lit;
   logic [WIN_AW-1:0] rd_addr;
   logic        adv;
   logic [7:0]  b_byte;

   logic [7:0]  first;
   logic [1:0]  need;
   logic [31:0] full;
   logic [12:0] span;
   logic [16:0] len;
   logic        done_chk;

   assign adv   = q_valid && (!b_vld_ff || rsp_tready);
   assign q_pop = adv;

   always_comb begin
      dc_in = dc_ff; ts_in = ts_ff; tc_in = tc_ff; hi_in = hi_ff; st_in = st_ff;
      v2_in = v2_ff; end_in = end_ff; fb_in = fb_ff; fp_in = fp_ff;
      tbc_in = tbc_ff; cr_in = cr_ff; co_in = co_ff;
      ov = 1'b0; is_cp = 1'b0; done_now = 1'b0; stat = ST_OK; lit = q_item.data;
      rd_addr = dc_ff[WIN_AW-1:0] - co_ff - 12'd1;
      first = (tbc_ff == 2'd0) ? q_item.data : 8'(tc_ff >> (8 * (tbc_ff - 2'd1)));
      if (!v2_ff) need = 2'd2;
      else if (first[7:4] == 4'd0) need = 2'd3;
      else if (first[7:4] == 4'd1) need = 2'd0;
      else need = 2'd2;
      full = {tc_ff[23:0], q_item.data};
      span = {1'b0, full[11:0]} + 13'd1;
      if (!v2_ff) len = 17'(full[15:12]) + 17'd3;
      else if (first[7:4] == 4'd0) len = 17'(full[19:12]) + 17'h11;
      else if (first[7:4] == 4'd1) len = 17'(full[27:12]) + 17'h111;
      else len = 17'(full[15:12]) + 17'd1;
      done_chk = 1'b0;
      if (q_item.start) begin
         dc_in = '0; ts_in = '0; tc_in = '0; hi_in = '0; st_in = ST_OK; v2_in = 1'b0;
         end_in = 1'b0; fb_in = '0; fp_in = FLAG_EMPTY; tbc_in = '0; cr_in = '0;
         co_in = '0;
      end else if (st_ff != ST_OK) begin
      end else if (q_item.drain) begin
         if (cr_ff != 17'd0) begin
            ov = 1'b1; is_cp = 1'b1;
            dc_in = dc_ff + 24'd1;
            cr_in = cr_ff - 17'd1;
            done_chk = (hi_ff == HDR_DONE) && (dc_in >= ts_ff);
            if (done_chk) begin
               cr_in = '0; done_now = 1'b1;
            end
            if (cr_in == 17'd0 && end_ff && !done_chk) st_in = ST_TRUNC;
         end
      end else if (q_item.feed) begin
         if ((hi_ff == HDR_DONE) && (dc_ff >= ts_ff)) begin
         end else if (cr_ff != 17'd0) begin
            stat = ST_BUSY;
         end else begin
            if (q_item.last) end_in = 1'b1;
            if (hi_ff != HDR_DONE) begin
               if (hi_ff == 3'd0) begin
                  if (q_item.data[7:4] != 4'd1 || q_item.data[3:0] > 4'd1) st_in = ST_BAD_HDR;
                  else v2_in = q_item.data[0];
               end else begin
                  ts_in = ts_ff | (24'(q_item.data) << (8 * (hi_ff - 3'd1)));
               end
               if (st_in == ST_OK) begin
                  hi_in = hi_ff + 3'd1;
                  if (hi_in == HDR_DONE) begin
                     if (limit_ff != 24'd0 && limit_ff < ts_in) ts_in = limit_ff;
                     if (dc_ff >= ts_in) done_now = 1'b1;
                  end else if (q_item.last) begin
                     st_in = ST_BAD_HDR;
                  end
               end
            end else if (fp_ff >= FLAG_EMPTY) begin
               fb_in = q_item.data;
               fp_in = 4'd0;
            end else if (!fb_ff[3'd7 - fp_ff[2:0]]) begin
               ov = 1'b1;
               dc_in = dc_ff + 24'd1;
               fp_in = fp_ff + 4'd1;
               if (dc_in >= ts_ff) done_now = 1'b1;
            end else begin
               if (tbc_ff + 2'd1 == need || (need == 2'd2 && tbc_ff != 2'd0)) begin
                  tc_in = '0; tbc_in = '0;
                  fp_in = fp_ff + 4'd1;
                  if (24'(span) > dc_ff) st_in = ST_BAD_REF;
                  else begin
                     co_in = full[11:0];
                     cr_in = len;
                  end
               end else begin
                  tc_in = {tc_ff[15:0], q_item.data};
                  tbc_in = tbc_ff + 2'd1;
               end
            end
            if (st_in == ST_OK && end_in && cr_in == 17'd0 &&
                !((hi_in == HDR_DONE) && (dc_in >= ts_in))) st_in = ST_TRUNC;
         end
      end
      if (st_in != ST_OK) stat = st_in;
   end

   assign b_byte = !b_ov_ff ? 8'd0 : (b_cp_ff ? (fwd_ff ? fwd_data_ff : rd_ff) : b_lit_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
         dc_ff <= '0; ts_ff <= '0; tc_ff <= '0; hi_ff <= '0; st_ff <= ST_OK;
         v2_ff <= 1'b0; end_ff <= 1'b0; fb_ff <= '0; fp_ff <= FLAG_EMPTY;
         tbc_ff <= '0; cr_ff <= '0; co_ff <= '0;
         b_vld_ff <= 1'b0; wr_pend_ff <= 1'b0;
      end else begin
         if (csr_wr_en) limit_ff <= csr_wr_data;
         if (adv) begin
            dc_ff <= dc_in; ts_ff <= ts_in; tc_ff <= tc_in; hi_ff <= hi_in;
            st_ff <= st_in; v2_ff <= v2_in; end_ff <= end_in; fb_ff <= fb_in;
            fp_ff <= fp_in; tbc_ff <= tbc_in; cr_ff <= cr_in; co_ff <= co_in;
            b_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            b_vld_ff <= 1'b0;
         end
         wr_pend_ff <= adv && ov;
      end
      if (adv) begin
         b_ov_ff <= ov; b_cp_ff <= is_cp; b_done_ff <= done_now;
         b_pend_ff <= (cr_in != 17'd0); b_stat_ff <= stat; b_lit_ff <= lit;
         wr_addr_ff <= dc_ff[WIN_AW-1:0];
         rd_ff <= hist[rd_addr];
         fwd_ff <= wr_pend_ff && (rd_addr == wr_addr_ff);
         fwd_data_ff <= b_byte;
      end
      if (wr_pend_ff) hist[wr_addr_ff] <= b_byte;
   end

   assign rsp_tvalid = b_vld_ff;
   assign rsp_tuser  = b_ov_ff;
   assign rsp_tlast  = b_done_ff;
   assign rsp_tdata  = {4'd0, b_stat_ff, b_pend_ff, b_byte};

   a_wr_has_rsp: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> b_vld_ff) else $error("history write without result");
   a_err_no_copy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != ST_OK) |-> (cr_ff == 17'd0)) else $error("copy pending after error");
   a_hdr_range: assert property (@(posedge clock) disable iff (reset)
      hi_ff <= HDR_DONE) else $error("header index out of range");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (b_vld_ff && !rsp_tready) |=> $stable(b_byte)) else $error("stalled byte changed");

endmodule
`default_nettype wire

// ----- tb/sv/lz_stream_decompressor_top_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module lz_stream_decompressor_top_tb;
   import lzd_pkg::*;

   typedef struct {
      logic       out_valid;
      logic [7:0] out_byte;
      logic       stream_done;
      logic       copy_pending;
      logic [2:0] status;
   } decoded_rsp_type;

   class lz_scoreboard;
      logic [7:0]     window [WINDOW_DEPTH];
      logic [23:0]    limit_reg;
      logic [23:0]    written, target;
      logic [2:0]     hdr_idx;
      logic           lz11;
      logic [7:0]     flags;
      logic [3:0]     flag_pos;
      logic [23:0]    tok;
      logic [1:0]     tok_cnt;
      logic [16:0]    copy_left;
      logic [11:0]    copy_off;
      logic           ended;
      logic [2:0]     state;
      decoded_rsp_type pending_rsp[$];
      int             errors;

      function void clear_stream();
         written = 0; target = 0; hdr_idx = 0; lz11 = 0; flags = 0;
         flag_pos = FLAG_EMPTY; tok = 0; tok_cnt = 0; copy_left = 0;
         copy_off = 0; ended = 0; state = ST_OK;
      endfunction

      function bit done_now();
         return hdr_idx == HDR_DONE && written >= target;
      endfunction

      function void push_byte(logic [7:0] b);
         window[written[11:0]] = b;
         written = 24'(written + 1);
      endfunction

      function int need(logic [7:0] first);
         if (!lz11) return 2;
         if (first[7:4] == 0) return 3;
         if (first[7:4] == 1) return 4;
         return 2;
      endfunction

      function void note_request(logic [1:0] act, logic [7:0] b, logic last);
         decoded_rsp_type r;
         logic [7:0] first;
         logic [31:0] full, span, len;
         r = '{0, 0, 0, 0, ST_OK};
         if (act == ACT_START) begin
            clear_stream();
         end else if (state != ST_OK) begin
         end else if (act == ACT_DRAIN) begin
            if (copy_left > 0) begin
               r.out_byte = window[written[11:0] - copy_off - 12'd1];
               r.out_valid = 1;
               push_byte(r.out_byte);
               copy_left--;
               if (done_now()) begin
                  copy_left = 0; r.stream_done = 1;
               end
               if (copy_left == 0 && ended && !done_now()) state = ST_TRUNC;
            end
         end else if (act == ACT_FEED) begin
            if (done_now()) begin
            end else if (copy_left > 0) begin
               r.status = ST_BUSY;
            end else begin
               if (last) ended = 1;
               if (hdr_idx < HDR_DONE) begin
                  if (hdr_idx == 0) begin
                     if (b[7:4] != 1 || b[3:0] > 1) state = ST_BAD_HDR;
                     else lz11 = b[0];
                  end else begin
                     target = target | (24'(b) << (8 * (hdr_idx - 1)));
                  end
                  if (state == ST_OK) begin
                     hdr_idx++;
                     if (hdr_idx == HDR_DONE) begin
                        if (limit_reg != 0 && limit_reg < target) target = limit_reg;
                        if (done_now()) r.stream_done = 1;
                     end else if (last) begin
                        state = ST_BAD_HDR;
                     end
                  end
               end else if (flag_pos >= FLAG_EMPTY) begin
                  flags = b; flag_pos = 0;
               end else if (flags[7 - flag_pos] == 0) begin
                  r.out_valid = 1; r.out_byte = b;
                  push_byte(b);
                  flag_pos++;
                  if (done_now()) r.stream_done = 1;
               end else begin
                  first = (tok_cnt == 0) ? b : 8'(tok >> (8 * (tok_cnt - 1)));
                  if (tok_cnt + 1 >= need(first)) begin
                     full = {tok, b};
                     span = full[11:0] + 1;
                     if (!lz11) len = full[15:12] + 3;
                     else if (first[7:4] == 0) len = full[19:12] + 'h11;
                     else if (first[7:4] == 1) len = full[27:12] + 'h111;
                     else len = full[15:12] + 1;
                     tok = 0; tok_cnt = 0; flag_pos++;
                     if (span > written) state = ST_BAD_REF;
                     else begin
                        copy_off = 12'(span - 1); copy_left = 17'(len);
                     end
                  end else begin
                     tok = {tok[15:0], b};
                     tok_cnt++;
                  end
               end
               if (state == ST_OK && ended && !done_now() && copy_left == 0)
                  state = ST_TRUNC;
            end
         end
         if (state != ST_OK) r.status = state;
         r.copy_pending = copy_left > 0;
         pending_rsp.insert(pending_rsp.size(), r);
      endfunction

      function void check_response(logic [15:0] data, logic user, logic last);
         decoded_rsp_type e;
         if (pending_rsp.size() == 0) begin
            $error("response with nothing pending");
            errors++;
            return;
         end
         e = pending_rsp.pop_front();
         if (user !== e.out_valid) begin
            $error("out_valid exp %0d got %0d", e.out_valid, user); errors++;
         end
         if (data[7:0] !== e.out_byte) begin
            $error("out_byte exp %0h got %0h", e.out_byte, data[7:0]); errors++;
         end
         if (last !== e.stream_done) begin
            $error("stream_done exp %0d got %0d", e.stream_done, last); errors++;
         end
         if (data[8] !== e.copy_pending) begin
            $error("copy_pending exp %0d got %0d", e.copy_pending, data[8]); errors++;
         end
         if (data[11:9] !== e.status) begin
            $error("status exp %0d got %0d", e.status, data[11:9]); errors++;
         end
      endfunction
   endclass

   logic        clock = 0, reset = 1;
   logic        req_tvalid = 0, req_tlast = 0;
   logic [7:0]  req_tdata = 0;
   logic [1:0]  req_tuser = 0;
   logic        req_tready, rsp_tvalid, rsp_tready = 0, rsp_tuser, rsp_tlast;
   logic [15:0] rsp_tdata;
   logic        csr_wr_en = 0;
   logic [23:0] csr_wr_data = 0;
   int          cycles = 0;
   int          stim_count = 0;
   bit          stim_done = 0;
   lz_scoreboard sb = new();

   lz_stream_decompressor_top dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   function int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   initial begin
      int g;
      wait (!reset);
      forever begin
         g = gap_len();
         if (g > 0) begin
            rsp_tready <= 0;
            repeat (g) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
      end
   end

   task automatic send_request(logic [1:0] act, logic [7:0] b, logic last);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1; req_tuser <= act; req_tdata <= b; req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(act, b, last);
      stim_count++;
   endtask

   task automatic settle();
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(logic [23:0] v);
      csr_wr_en <= 1; csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.limit_reg = v;
      @(posedge clock);
   endtask

   task automatic drain_all();
      while (sb.copy_left > 0 && sb.state == ST_OK) send_request(ACT_DRAIN, 0, 0);
   endtask

   task automatic feed(logic [7:0] b, logic last = 0);
      send_request(ACT_FEED, b, last);
      drain_all();
   endtask

   // build a random stream of literals and refs, some malformed
   task automatic random_stream(int size, bit lz11, bit truncate);
      int produced, k, span, len;
      logic [7:0] fl;
      send_request(ACT_START, 8'($urandom), 1'($urandom));
      feed({4'h1, 3'b0, lz11});
      feed(size[7:0]); feed(size[15:8]); feed(size[23:16]);
      produced = 0;
      while (produced < size && sb.state == ST_OK && !sb.done_now()) begin
         fl = 8'($urandom);
         feed(fl);
         for (k = 7; k >= 0 && produced < size && sb.state == ST_OK; k--) begin
            if (truncate && $urandom_range(0, 30) == 0) begin
               feed(8'($urandom), 1);
               return;
            end
            if (fl[k] == 0 || produced == 0) begin
               if (fl[k]) begin
                  feed(8'($urandom)); feed(8'($urandom));
               end else begin
                  feed(8'($urandom));
                  produced++;
               end
            end else begin
               span = $urandom_range(1, produced > 4096 ? 4096 : produced);
               if ($urandom_range(0, 9) == 0) span = produced + 1;
               span = span - 1;
               if (!lz11) begin
                  len = $urandom_range(0, 15);
                  feed({len[3:0], span[11:8]}); feed(span[7:0]);
                  produced += len + 3;
               end else begin
                  case ($urandom_range(0, 5))
                     0: begin
                        len = $urandom_range(0, 20);
                        feed({4'h0, len[7:4]}); feed({len[3:0], span[11:8]});
                        feed(span[7:0]);
                        produced += len + 'h11;
                     end
                     1: begin
                        len = $urandom_range(0, 40);
                        if ($urandom_range(0, 30) == 0) len = 16'hffff;
                        feed({4'h1, len[15:12]}); feed(len[11:4]);
                        feed({len[3:0], span[11:8]}); feed(span[7:0]);
                        produced += len + 'h111;
                     end
                     default: begin
                        len = $urandom_range(2, 15);
                        feed({len[3:0], span[11:8]}); feed(span[7:0]);
                        produced += len + 1;
                     end
                  endcase
               end
            end
         end
      end
      if ($urandom_range(0, 1)) feed(8'($urandom), 1'($urandom));
   endtask

   initial begin
      int n;
      sb.clear_stream();
      sb.limit_reg = 0;
      sb.errors = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed
      write_limit(24'hffffff);
      send_request(ACT_START, 8'hff, 1);
      send_request(ACT_FEED, 8'h20, 0);
      send_request(ACT_NONE, 8'h00, 0);
      send_request(ACT_START, 0, 0);
      send_request(ACT_FEED, 8'h12, 0);
      send_request(ACT_START, 0, 0);
      send_request(ACT_FEED, 8'h10, 0);
      send_request(ACT_FEED, 8'h05, 1);
      send_request(ACT_START, 0, 0);
      send_request(ACT_FEED, 8'h11, 0);
      send_request(ACT_FEED, 8'h00, 0);
      send_request(ACT_FEED, 8'h00, 0);
      send_request(ACT_FEED, 8'h00, 0);
      send_request(ACT_FEED, 8'hff, 0);
      send_request(ACT_START, 0, 0);
      send_request(ACT_FEED, 8'h10, 0);
      send_request(ACT_FEED, 8'h08, 0);
      send_request(ACT_FEED, 8'h00, 0);
      send_request(ACT_FEED, 8'h00, 0);
      send_request(ACT_FEED, 8'h40, 0);
      send_request(ACT_FEED, 8'haa, 0);
      send_request(ACT_FEED, 8'h10, 0);
      send_request(ACT_FEED, 8'h00, 0);
      send_request(ACT_FEED, 8'h55, 0);
      send_request(ACT_DRAIN, 0, 0);
      drain_all();
      send_request(ACT_FEED, 8'h01, 1);
      settle();
      write_limit(0);
      while (stim_count < 400)
         random_stream($urandom_range(1, 40), 1'($urandom), $urandom_range(0, 3) == 0);
      settle();
      write_limit(24'd5);
      random_stream(30, 1, 0);
      random_stream(30, 0, 0);
      settle();
      write_limit(24'd1);
      random_stream(10, 1, 0);
      settle();
      write_limit(24'd25);
      while (stim_count < 750) begin
         if ($urandom_range(0, 9) == 0) begin
            for (n = 0; n < 6; n++)
               send_request(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
            drain_all();
         end else begin
            random_stream($urandom_range(1, 60), 1'($urandom), $urandom_range(0, 4) == 0);
         end
      end
      settle();
      write_limit(0);
      if (sb.errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
`default_nettype wire
